/* rtl/core/ffa_pkg.sv */
// Shared field widths, codes and width helper for the first-fit heap allocator.
package ffa_pkg;

  localparam int unsigned OPCODE_W = 1;
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } ffa_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_FIT   = 2'd1,
    STATUS_BAD_ADDR = 2'd2
  } ffa_status_e;

  function automatic int unsigned ffa_word_w(input int unsigned heap, input int unsigned hdr);
    return $clog2(heap + 2 * hdr + (2 ** SIZE_W) + 1);
  endfunction

endpackage

/* rtl/core/ffa_req_if.sv */
// Request channel: opcode, requested size and data address to free.
interface ffa_req_if import ffa_pkg::*; ();
  logic              valid;
  logic              ready;
  ffa_op_e           opcode;
  logic [SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0] data_address;

  modport source (output valid, output opcode, output request_size, output data_address,
                  input ready);
  modport sink   (input valid, input opcode, input request_size, input data_address,
                  output ready);
endinterface

/* rtl/core/ffa_rsp_if.sv */
// Response channel: status and granted data address.
interface ffa_rsp_if import ffa_pkg::*; ();
  logic              valid;
  logic              ready;
  ffa_status_e       status;
  logic [ADDR_W-1:0] granted_address;

  modport source (output valid, output status, output granted_address, input ready);
  modport sink   (input valid, input status, input granted_address, output ready);
endinterface

/* rtl/core/ffa_table.sv */
// Block table memory: one write port, one registered read port, entry 0 reset overlay.
module ffa_table import ffa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEAP_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 16,
  localparam int unsigned WW = ffa_word_w(HEAP_BYTES, HEADER_BYTES),
  localparam int unsigned AW = $clog2(MAX_BLOCKS),
  localparam int unsigned EW = 2 * WW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [AW-1:0] rd_addr_i,
  output logic [EW-1:0] rd_data_o,
  input  logic          we_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [EW-1:0] wr_data_i
);

  localparam logic [EW-1:0] ResetEntry = {WW'(0), WW'(HEAP_BYTES), 1'b0};

  logic [EW-1:0] mem [MAX_BLOCKS];
  logic [EW-1:0] rd_q;
  logic          init_q;
  logic          rd_init_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q    <= 1'b1;
      rd_init_q <= 1'b0;
    end else begin
      if (we_i && (wr_addr_i == AW'(0))) begin
        init_q <= 1'b0;
      end
      rd_init_q <= init_q && (rd_addr_i == AW'(0));
    end
  end

  assign rd_data_o = rd_init_q ? ResetEntry : rd_q;

endmodule

/* rtl/core/ffa_ctrl.sv */
// Sequencer: first-fit scan, split insert and coalescing removal over the block table.
module ffa_ctrl import ffa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEAP_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 16,
  localparam int unsigned WW = ffa_word_w(HEAP_BYTES, HEADER_BYTES),
  localparam int unsigned AW = $clog2(MAX_BLOCKS),
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1),
  localparam int unsigned EW = 2 * WW + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ffa_op_e           op_i,
  input  logic [SIZE_W-1:0] size_i,
  input  logic [ADDR_W-1:0] addr_i,
  output logic              idle_o,
  output logic              done_o,
  input  logic              ack_i,
  output ffa_status_e       status_o,
  output logic [ADDR_W-1:0] granted_o,
  output logic [AW-1:0]     rd_addr_o,
  input  logic [EW-1:0]     rd_data_i,
  output logic              we_o,
  output logic [AW-1:0]     wr_addr_o,
  output logic [EW-1:0]     wr_data_o
);

  typedef struct packed {
    logic [WW-1:0] start;
    logic [WW-1:0] len;
    logic          used;
  } entry_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_MERGE = 6'b000100,
    S_SHUP  = 6'b001000,
    S_SHDN  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  localparam logic [WW-1:0] Hdr = WW'(HEADER_BYTES);

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              rv_q, rv_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     dix_q, dix_d;
  logic [CW-1:0]     src_q, src_d;
  logic [CW-1:0]     bnd_q, bnd_d;
  logic [1:0]        ofs_q, ofs_d;
  logic [CW-1:0]     hidx_q, hidx_d;
  entry_t            prev_q, prev_d;
  entry_t            hit_q, hit_d;
  entry_t            ins_q, ins_d;
  ffa_op_e           op_q, op_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  ffa_status_e       status_q, status_d;
  logic [ADDR_W-1:0] gaddr_q, gaddr_d;

  entry_t        e;
  logic [WW-1:0] need;
  logic [WW-1:0] rest;
  logic [WW-1:0] data_off;
  logic          fit;
  logic          match;
  logic          hit;
  logic          split;
  logic          issue_scan;
  logic          n_ok;
  logic          p_ok;
  logic [1:0]    n_rm;
  logic [WW-1:0] len_mid;
  logic [WW-1:0] len_all;
  logic          more_up;
  logic          more_dn;

  assign e          = entry_t'(rd_data_i);
  assign need       = WW'(size_q) + Hdr;
  assign rest       = e.len - need;
  assign data_off   = e.start + Hdr;
  assign fit        = !e.used && (e.len >= need);
  assign match      = e.used && (data_off == WW'(addr_q));
  assign hit        = rv_q && ((op_q == OP_ALLOC) ? fit : match);
  assign split      = (rest > Hdr) && (cnt_q < CW'(MAX_BLOCKS));
  assign issue_scan = (idx_q < cnt_q) && !(hit && (op_q == OP_ALLOC));
  assign n_ok       = rv_q && !e.used;
  assign p_ok       = (hidx_q != CW'(0)) && !prev_q.used;
  assign n_rm       = {1'b0, p_ok} + {1'b0, n_ok};
  assign len_mid    = hit_q.len + (n_ok ? (Hdr + e.len) : WW'(0));
  assign len_all    = prev_q.len + Hdr + len_mid;
  assign more_up    = src_q >= bnd_q;
  assign more_dn    = src_q < bnd_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rv_d      = 1'b0;
    idx_d     = idx_q;
    dix_d     = dix_q;
    src_d     = src_q;
    bnd_d     = bnd_q;
    ofs_d     = ofs_q;
    hidx_d    = hidx_q;
    prev_d    = prev_q;
    hit_d     = hit_q;
    ins_d     = ins_q;
    op_d      = op_q;
    size_d    = size_q;
    addr_d    = addr_q;
    status_d  = status_q;
    gaddr_d   = gaddr_q;
    rd_addr_o = idx_q[AW-1:0];
    we_o      = 1'b0;
    wr_addr_o = dix_q[AW-1:0];
    wr_data_o = rd_data_i;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d    = op_i;
          size_d  = size_i;
          addr_d  = addr_i;
          idx_d   = CW'(0);
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        if (issue_scan) begin
          rd_addr_o = idx_q[AW-1:0];
          dix_d     = idx_q;
          idx_d     = idx_q + CW'(1);
          rv_d      = 1'b1;
        end
        if (hit) begin
          if (op_q == OP_ALLOC) begin
            we_o      = 1'b1;
            wr_addr_o = dix_q[AW-1:0];
            wr_data_o = entry_t'{start: e.start, len: (split ? WW'(size_q) : e.len),
                                 used: 1'b1};
            status_d  = STATUS_OK;
            gaddr_d   = data_off[ADDR_W-1:0];
            if (split) begin
              ins_d   = entry_t'{start: e.start + need, len: rest, used: 1'b0};
              src_d   = cnt_q - CW'(1);
              bnd_d   = dix_q + CW'(1);
              cnt_d   = cnt_q + CW'(1);
              state_d = S_SHUP;
            end else begin
              state_d = S_RESP;
            end
          end else begin
            hit_d   = e;
            hidx_d  = dix_q;
            state_d = S_MERGE;
          end
        end else if (rv_q) begin
          prev_d = e;
        end else if (!issue_scan) begin
          status_d = (op_q == OP_ALLOC) ? STATUS_NO_FIT : STATUS_BAD_ADDR;
          gaddr_d  = '0;
          state_d  = S_RESP;
        end
      end

      S_MERGE: begin
        we_o     = 1'b1;
        status_d = STATUS_OK;
        gaddr_d  = '0;
        if (p_ok) begin
          wr_addr_o = AW'(hidx_q - CW'(1));
          wr_data_o = entry_t'{start: prev_q.start, len: len_all, used: 1'b0};
          src_d     = hidx_q + CW'(n_rm);
        end else begin
          wr_addr_o = hidx_q[AW-1:0];
          wr_data_o = entry_t'{start: hit_q.start, len: len_mid, used: 1'b0};
          src_d     = hidx_q + CW'(1) + CW'(n_rm);
        end
        bnd_d   = cnt_q;
        ofs_d   = n_rm;
        cnt_d   = cnt_q - CW'(n_rm);
        state_d = (n_rm == 2'd0) ? S_RESP : S_SHDN;
      end

      S_SHUP: begin
        if (more_up) begin
          rd_addr_o = src_q[AW-1:0];
          dix_d     = src_q;
          src_d     = src_q - CW'(1);
          rv_d      = 1'b1;
        end
        if (rv_q) begin
          we_o      = 1'b1;
          wr_addr_o = AW'(dix_q + CW'(1));
          wr_data_o = rd_data_i;
        end else if (!more_up) begin
          we_o      = 1'b1;
          wr_addr_o = bnd_q[AW-1:0];
          wr_data_o = ins_q;
          state_d   = S_RESP;
        end
      end

      S_SHDN: begin
        if (more_dn) begin
          rd_addr_o = src_q[AW-1:0];
          dix_d     = src_q;
          src_d     = src_q + CW'(1);
          rv_d      = 1'b1;
        end
        if (rv_q) begin
          we_o      = 1'b1;
          wr_addr_o = AW'(dix_q - CW'(ofs_q));
          wr_data_o = rd_data_i;
        end else if (!more_dn) begin
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= CW'(1);
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    dix_q    <= dix_d;
    src_q    <= src_d;
    bnd_q    <= bnd_d;
    ofs_q    <= ofs_d;
    hidx_q   <= hidx_d;
    prev_q   <= prev_d;
    hit_q    <= hit_d;
    ins_q    <= ins_d;
    op_q     <= op_d;
    size_q   <= size_d;
    addr_q   <= addr_d;
    status_q <= status_d;
    gaddr_q  <= gaddr_d;
  end

  assign idle_o    = (state_q == S_IDLE);
  assign done_o    = (state_q == S_RESP);
  assign status_o  = status_q;
  assign granted_o = gaddr_q;

endmodule

/* rtl/core/first_fit_heap_allocator_top.sv */
// Top level of the first-fit heap allocator: channels, sequencer, table and response register.
// A request walks the address-ordered block table one entry per cycle through the single
// read port of the table memory. A free also makes a merge write after its scan. An
// allocate that splits a block then moves every later entry up by one, and a free that
// coalesces moves every later entry down, one entry per cycle. The scan stops where the move
// starts, so the two together cover the table once. A new request is taken only when the
// sequencer is idle; a finished response waits in the output register while the next
// request runs. There is no clearing pass after reset.
module first_fit_heap_allocator_top import ffa_pkg::*; #(
  parameter int unsigned HEAP_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned MAX_BLOCKS   = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  ffa_req_if.sink   req_i,
  ffa_rsp_if.source rsp_o
);

  localparam int unsigned WW = ffa_word_w(HEAP_BYTES, HEADER_BYTES);
  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam int unsigned EW = 2 * WW + 1;

  logic              idle;
  logic              done;
  logic              ack;
  logic              start;
  ffa_status_e       status;
  logic [ADDR_W-1:0] granted;
  logic [AW-1:0]     rd_addr;
  logic [EW-1:0]     rd_data;
  logic              we;
  logic [AW-1:0]     wr_addr;
  logic [EW-1:0]     wr_data;

  logic              rsp_valid_q, rsp_valid_d;
  ffa_status_e       rsp_status_q;
  logic [ADDR_W-1:0] rsp_addr_q;

  assign req_i.ready = idle;
  assign start       = req_i.valid && idle;
  assign ack         = done && (!rsp_valid_q || rsp_o.ready);

  ffa_ctrl #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .op_i      (req_i.opcode),
    .size_i    (req_i.request_size),
    .addr_i    (req_i.data_address),
    .idle_o    (idle),
    .done_o    (done),
    .ack_i     (ack),
    .status_o  (status),
    .granted_o (granted),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .we_o      (we),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

  ffa_table #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .we_i      (we),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (ack) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack) begin
      rsp_status_q <= status;
      rsp_addr_q   <= granted;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = rsp_status_q;
  assign rsp_o.granted_address = rsp_addr_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !idle)
    else $error("sequencer still idle after a request transaction");

  a_idle_done_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({idle, done}))
    else $error("sequencer idle and done at once");

  a_addr_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ack |=> (rsp_valid_q && ((rsp_status_q == STATUS_OK) || (rsp_addr_q == '0))))
    else $error("response lost or error response carries a nonzero address");

endmodule

/* tb/ffa_heap_checker.sv */
// Checker for the first-fit heap allocator: shadow block table, expected responses, comparison.
module ffa_heap_checker import ffa_pkg::*; #(
  parameter int unsigned HEAP_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned MAX_BLOCKS   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffa_req_if          req_if,
  ffa_rsp_if          rsp_if,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned no_fit_o,
  output int unsigned bad_addr_o,
  output int unsigned table_full_o,
  output int unsigned peak_blocks_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ffa_status_e       status;
    logic [ADDR_W-1:0] granted_address;
  } heap_grant_t;

  heap_grant_t       grant_q [$];
  logic [ADDR_W-1:0] blk_start [MAX_BLOCKS];
  logic [SIZE_W-1:0] blk_len   [MAX_BLOCKS];
  logic              blk_used  [MAX_BLOCKS];
  int unsigned       blk_count;
  int unsigned       fails;
  int unsigned       checked;
  int unsigned       no_fits;
  int unsigned       bad_addrs;
  int unsigned       full_hits;
  int unsigned       peak_blocks;

  function automatic void clear_table();
    for (int unsigned k = 0; k < MAX_BLOCKS; k++) begin
      blk_start[k] = '0;
      blk_len[k]   = '0;
      blk_used[k]  = 1'b0;
    end
    blk_len[0] = SIZE_W'(HEAP_BYTES);
    blk_count  = 1;
  endfunction

  function automatic void drop_entry(input int unsigned idx);
    for (int unsigned k = idx; k + 1 < blk_count; k++) begin
      blk_start[k] = blk_start[k+1];
      blk_len[k]   = blk_len[k+1];
      blk_used[k]  = blk_used[k+1];
    end
    blk_count--;
  endfunction

  function automatic heap_grant_t predict_alloc(input logic [SIZE_W-1:0] size);
    heap_grant_t res;
    int unsigned need;
    int unsigned rest;
    int unsigned slot;
    bit          found;
    res.status          = STATUS_NO_FIT;
    res.granted_address = '0;
    found = 1'b0;
    slot  = 0;
    need  = int'(size) + HEADER_BYTES;
    for (int unsigned i = 0; i < blk_count; i++) begin
      if (!found && !blk_used[i] && int'(blk_len[i]) >= need) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (found) begin
      rest = int'(blk_len[slot]) - need;
      blk_used[slot] = 1'b1;
      if (rest > HEADER_BYTES) begin
        if (blk_count < MAX_BLOCKS) begin
          for (int unsigned k = blk_count; k > slot + 1; k--) begin
            blk_start[k] = blk_start[k-1];
            blk_len[k]   = blk_len[k-1];
            blk_used[k]  = blk_used[k-1];
          end
          blk_count++;
          blk_len[slot]     = size;
          blk_start[slot+1] = ADDR_W'(int'(blk_start[slot]) + need);
          blk_len[slot+1]   = SIZE_W'(rest);
          blk_used[slot+1]  = 1'b0;
        end else begin
          full_hits++;
        end
      end
      res.status          = STATUS_OK;
      res.granted_address = ADDR_W'(int'(blk_start[slot]) + HEADER_BYTES);
    end
    return res;
  endfunction

  function automatic heap_grant_t predict_free(input logic [ADDR_W-1:0] addr);
    heap_grant_t res;
    int unsigned slot;
    bit          found;
    res.status          = STATUS_BAD_ADDR;
    res.granted_address = '0;
    found = 1'b0;
    slot  = 0;
    for (int unsigned i = 0; i < blk_count; i++) begin
      if (!found && blk_used[i] && int'(blk_start[i]) + HEADER_BYTES == int'(addr)) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (found) begin
      blk_used[slot] = 1'b0;
      if (slot + 1 < blk_count && !blk_used[slot+1]) begin
        blk_len[slot] = SIZE_W'(int'(blk_len[slot]) + HEADER_BYTES + int'(blk_len[slot+1]));
        drop_entry(slot + 1);
      end
      if (slot > 0 && !blk_used[slot-1]) begin
        blk_len[slot-1] = SIZE_W'(int'(blk_len[slot-1]) + HEADER_BYTES + int'(blk_len[slot]));
        drop_entry(slot);
      end
      res.status = STATUS_OK;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    heap_grant_t want;
    if (!rst_ni) begin
      clear_table();
      grant_q.delete();
      fails       = 0;
      checked     = 0;
      no_fits     = 0;
      bad_addrs   = 0;
      full_hits   = 0;
      peak_blocks = 1;
    end else begin
      if (req_if.valid && req_if.ready) begin
        if (req_if.opcode == OP_ALLOC) begin
          want = predict_alloc(req_if.request_size);
        end else begin
          want = predict_free(req_if.data_address);
        end
        if (want.status == STATUS_NO_FIT) no_fits++;
        if (want.status == STATUS_BAD_ADDR) bad_addrs++;
        if (blk_count > peak_blocks) peak_blocks = blk_count;
        grant_q.push_back(want);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        checked++;
        if (grant_q.size() == 0) begin
          $error("response with none expected: status %0d granted_address %0d",
                 rsp_if.status, rsp_if.granted_address);
          fails++;
        end else begin
          want = grant_q.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("field status: expected %0d, actual %0d", want.status, rsp_if.status);
            fails++;
          end
          if (rsp_if.granted_address !== want.granted_address) begin
            $error("field granted_address: expected %0d, actual %0d",
                   want.granted_address, rsp_if.granted_address);
            fails++;
          end
        end
      end
    end
    fail_count_o  <= fails;
    pending_o     <= grant_q.size();
    checked_o     <= checked;
    no_fit_o      <= no_fits;
    bad_addr_o    <= bad_addrs;
    table_full_o  <= full_hits;
    peak_blocks_o <= peak_blocks;
  end

endmodule

/* tb/tb.sv */
// Testbench top for the first-fit heap allocator: clock, reset, stimulus, watchdog, verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffa_pkg::*;

  localparam int unsigned HEAP_BYTES       = 4096;
  localparam int unsigned HEADER_BYTES     = 16;
  localparam int unsigned MAX_BLOCKS       = 64;
  localparam int unsigned RANDOM_PER_PHASE = 226;
  localparam int unsigned BURST_LEN        = 80;
  localparam int unsigned DRAIN_CYCLES     = 2 * MAX_BLOCKS + 40;
  localparam int unsigned WATCHDOG_LIMIT   = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned req_idle_pct;
  int unsigned rsp_idle_pct;
  int unsigned idle_cycles;
  int unsigned live_q [$];
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned no_fits;
  int unsigned bad_addrs;
  int unsigned full_hits;
  int unsigned peak_blocks;

  ffa_req_if req_bus ();
  ffa_rsp_if rsp_bus ();

  first_fit_heap_allocator_top #(
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  ffa_heap_checker #(
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_if       (req_bus),
    .rsp_if       (rsp_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .no_fit_o     (no_fits),
    .bad_addr_o   (bad_addrs),
    .table_full_o (full_hits),
    .peak_blocks_o(peak_blocks)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready && rsp_bus.status == STATUS_OK &&
        rsp_bus.granted_address != '0) begin
      live_q.push_back(int'(rsp_bus.granted_address));
    end
  end

  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  task automatic send_request(input ffa_op_e op, input int unsigned arg);
    while ($urandom_range(99) < req_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.opcode       <= op;
    req_bus.request_size <= (op == OP_ALLOC) ? SIZE_W'(arg) : SIZE_W'($urandom);
    req_bus.data_address <= (op == OP_FREE) ? ADDR_W'(arg) : ADDR_W'($urandom);
    do @(posedge clk_i); while (!req_bus.ready);
    @(negedge clk_i);
  endtask

  task automatic send_random(input bit fill_burst);
    int unsigned roll;
    int unsigned pick;
    roll = $urandom_range(99);
    if (roll < (fill_burst ? 88 : 20)) begin
      roll = $urandom_range(99);
      if (roll < 75) send_request(OP_ALLOC, $urandom_range(40));
      else if (roll < 90) send_request(OP_ALLOC, $urandom_range(600));
      else if (roll < 96) send_request(OP_ALLOC, $urandom_range(4096));
      else send_request(OP_ALLOC, $urandom_range(8191));
    end else begin
      roll = $urandom_range(99);
      if (roll < 80 && live_q.size() > 0) begin
        pick = $urandom_range(live_q.size() - 1);
        send_request(OP_FREE, live_q[pick]);
        live_q.delete(pick);
      end else if (roll < 90 && live_q.size() > 0) begin
        pick = $urandom_range(live_q.size() - 1);
        send_request(OP_FREE, (live_q[pick] + $urandom_range(1, 15)) & 12'hFFF);
      end else begin
        send_request(OP_FREE, $urandom_range(4095));
      end
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    rst_ni               = 1'b0;
    req_bus.valid        = 1'b0;
    req_bus.opcode       = OP_ALLOC;
    req_bus.request_size = '0;
    req_bus.data_address = '0;
    req_idle_pct         = 36;
    rsp_idle_pct         = 58;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          req_idle_pct = 36;
          rsp_idle_pct = 58;
        end
        1: begin
          req_idle_pct = 58;
          rsp_idle_pct = 36;
        end
        default: begin
          req_idle_pct = 0;
          rsp_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        send_request(OP_ALLOC, 4096);
        send_request(OP_ALLOC, 4081);
        send_request(OP_ALLOC, 4080);
        send_request(OP_ALLOC, 0);
        send_request(OP_FREE, 16);
        send_request(OP_FREE, 16);
        send_request(OP_ALLOC, 4063);
        send_request(OP_ALLOC, 1);
        send_request(OP_ALLOC, 8191);
        send_request(OP_FREE, 4095);
        send_request(OP_FREE, 16);
        send_request(OP_ALLOC, 4064);
        send_request(OP_FREE, 16);
        send_request(OP_ALLOC, 0);
        send_request(OP_ALLOC, 0);
        send_request(OP_ALLOC, 100);
        send_request(OP_FREE, 32);
        send_request(OP_ALLOC, 200);
        send_request(OP_FREE, 16);
        send_request(OP_FREE, 0);
        send_request(OP_FREE, 4095);
        send_request(OP_FREE, 49);
        send_request(OP_FREE, 48);
        send_request(OP_FREE, 164);
      end
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_random(((n / BURST_LEN) % 2) == 0);
      end
    end
    req_bus.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d responses: %0d without a fit, %0d with an unknown address.",
             checked, no_fits, bad_addrs);
    $display("Block table peaked at %0d of %0d entries; %0d splits skipped on a full table.",
             peak_blocks, MAX_BLOCKS, full_hits);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ffa_pkg.sv
rtl/core/ffa_req_if.sv
rtl/core/ffa_rsp_if.sv
rtl/core/ffa_table.sv
rtl/core/ffa_ctrl.sv
rtl/core/first_fit_heap_allocator_top.sv
tb/ffa_heap_checker.sv
tb/tb.sv
